// ===== src/lrt_pkg.sv =====
`timescale 1ns / 1ps
package lrt_pkg;

    localparam int VAL_W = 32;
    localparam int ACC_W = 64;

    localparam logic [1:0] KIND_FEATURE = 2'd0;
    localparam logic [1:0] KIND_TARGET  = 2'd1;
    localparam logic [1:0] KIND_WEIGHT  = 2'd2;
    localparam logic [1:0] KIND_START   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [1:0] CFG_EPOCHS   = 2'd0;
    localparam logic [1:0] CFG_LRATE    = 2'd1;
    localparam logic [1:0] CFG_FEATURES = 2'd2;

    typedef struct packed {
        logic shift;
        logic gmul;
        logic gacc;
        logic gclr;
    } t_cell_ctrl;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

// ===== src/lrt_ram.sv =====
`timescale 1ns / 1ps
module lrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== src/lrt_cell.sv =====
`timescale 1ns / 1ps
module lrt_cell
    import lrt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctrl              i_ctrl,
    input  logic                    i_is_bias,
    input  logic signed [31:0]      i_x,
    input  logic signed [31:0]      i_err,
    input  logic                    i_wwr,
    input  logic signed [31:0]      i_wdata,
    output logic signed [31:0]      o_x,
    output logic signed [31:0]      o_w,
    output logic signed [63:0]      o_g
);
    logic signed [31:0] r_x;
    logic signed [31:0] r_w;
    logic signed [63:0] r_g;
    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_x <= i_x;
        end
        if (i_ctrl.gmul) begin
            r_p <= i_is_bias ? $signed({{16{i_err[31]}}, i_err, 16'd0}) : i_err * r_x;
        end
        if (!i_rst_n) begin
            r_w <= '0;
            r_g <= '0;
        end else begin
            if (i_wwr) begin
                r_w <= i_wdata;
            end
            if (i_ctrl.gclr) begin
                r_g <= '0;
            end else if (i_ctrl.gacc) begin
                r_g <= sat_add64(r_g, r_p);
            end
        end
    end

    assign o_x = r_x;
    assign o_w = r_w;
    assign o_g = r_g;
endmodule

// ===== src/lrt_div.sv =====
`timescale 1ns / 1ps
module lrt_div #(
    parameter int VW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [63:0]   i_dividend,
    input  logic [VW-1:0]        i_divisor,
    output logic                 o_busy,
    output logic                 o_done,
    output logic signed [63:0]   o_quo
);
    logic          r_busy;
    logic          r_done;
    logic [6:0]    r_cnt;
    logic          r_neg;
    logic [63:0]   r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   rem_sh;
    logic          take;

    assign rem_sh = {r_rem, r_quo[63]};
    assign take   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_neg  <= i_dividend[63];
                r_quo  <= i_dividend[63] ? 64'(-i_dividend) : i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= take ? VW'(rem_sh - {1'b0, r_div}) : rem_sh[VW-1:0];
                r_quo <= {r_quo[62:0], take};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_quo) : $signed(r_quo);
endmodule

// ===== src/linear_regression_trainer_unit.sv =====
`timescale 1ns / 1ps
// Batch gradient descent trainer for linear regression in signed Q16.16.
// Input stream: tuser carries the kind (feature, target, initial weight, start)
// and tdata the value. Loads are taken one per cycle while the block is idle.
// A start request runs the configured number of epochs over the stored rows and
// then emits one result per weight, index 0 up to the bias, with tlast on the
// bias. A start with no rows or a malformed data set gives one error result.
// Each epoch has a row pass, bounded by the feature memory read port and the
// serial prediction accumulator, and a weight update that takes one weight at a
// time through the one-bit-per-cycle divider that forms the mean gradient.
// The row cells hold one feature, weight and gradient sum each; features shift
// in along the chain and every cell updates its own gradient sum in parallel.
// The input is not ready while training or emitting. Results sit in an output
// register; a stall on the result side holds the emission without loss.
// Configuration writes are taken in any cycle and must be issued while idle.
// Reset restores the register defaults, zeroes weights and clears the load
// state; stored rows read as garbage until written again.
module linear_regression_trainer_unit
    import lrt_pkg::*;
#(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_FEATURES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // value
    input  logic [1:0]  i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // index, weight_value, status, zero pad
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    localparam int NC  = MAX_FEATURES + 1;
    localparam int JW  = $clog2(MAX_FEATURES + 2);
    localparam int WLW = $clog2(MAX_FEATURES + 3);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int FD  = MAX_ROWS * MAX_FEATURES;
    localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
    localparam int TAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EPOCH = 4'd1;
    localparam logic [3:0] S_ISSUE = 4'd2;
    localparam logic [3:0] S_DRAIN = 4'd3;
    localparam logic [3:0] S_PRED  = 4'd4;
    localparam logic [3:0] S_GMUL  = 4'd5;
    localparam logic [3:0] S_GACC  = 4'd6;
    localparam logic [3:0] S_UDIV  = 4'd7;
    localparam logic [3:0] S_UWAIT = 4'd8;
    localparam logic [3:0] S_UMUL  = 4'd9;
    localparam logic [3:0] S_UWR   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_ERRO  = 4'd12;

    logic [3:0]  r_state;
    logic [15:0] r_epochs;
    logic [16:0] r_lrate;
    logic [4:0]  r_fiu;
    logic [RW-1:0]  r_rows;
    logic [RW-1:0]  r_nrows;
    logic [JW-1:0]  r_col;
    logic [WLW-1:0] r_wl;
    logic           r_shape;
    logic [15:0]    r_ep;
    logic [RW-1:0]  r_r;
    logic [JW-1:0]  r_j;
    logic [JW-1:0]  r_j1;
    logic           r_v1;
    logic           r_v2;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_tgt;
    logic signed [31:0] r_err;
    logic signed [63:0] r_q;
    logic signed [49:0] r_stp;
    logic [1:0]         r_status;
    logic               r_ov;
    logic [39:0]        r_od;
    logic               r_ol;

    logic [JW-1:0] nf;
    logic          in_acc;
    logic [1:0]    kind;
    logic          start_ok;
    logic [1:0]    start_st;

    logic signed [31:0] x_arr [NC];
    logic signed [31:0] w_arr [NC];
    logic signed [63:0] g_arr [NC];
    logic signed [31:0] xin   [NC];
    logic               wwr   [NC];
    logic signed [31:0] wdat  [NC];
    t_cell_ctrl         cctl;

    logic           f_we;
    logic [FAW-1:0] f_addr;
    logic [31:0]    f_rdata;
    logic           t_we;
    logic [TAW-1:0] t_addr;
    logic [31:0]    t_rdata;

    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic signed [63:0] div_quo;
    logic               out_free;
    logic signed [31:0] w_new;

    always_comb begin
        if (r_fiu == 5'd0) begin
            nf = JW'(1);
        end else if (32'(r_fiu) > MAX_FEATURES) begin
            nf = JW'(MAX_FEATURES);
        end else begin
            nf = JW'(r_fiu);
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign kind        = i_s_tuser;
    assign out_free    = !r_ov || i_m_tready;

    always_comb begin
        if (r_rows == '0) begin
            start_st = STATUS_EMPTY;
        end else if (r_shape || r_col != '0 ||
                     (r_wl != '0 && 32'(r_wl) != 32'(nf) + 1)) begin
            start_st = STATUS_MISMATCH;
        end else begin
            start_st = STATUS_OK;
        end
        start_ok = (start_st == STATUS_OK);
    end

    assign f_we = in_acc && kind == KIND_FEATURE && 32'(r_col) < 32'(nf) &&
                  32'(r_rows) < MAX_ROWS;
    assign t_we = in_acc && kind == KIND_TARGET && 32'(r_rows) < MAX_ROWS;
    assign f_addr = (r_state == S_IDLE) ? FAW'(32'(r_rows) * MAX_FEATURES + 32'(r_col))
                                        : FAW'(32'(r_r) * MAX_FEATURES + 32'(r_j));
    assign t_addr = (r_state == S_IDLE) ? TAW'(r_rows) : TAW'(r_r);

    lrt_ram #(.WIDTH(32), .DEPTH(FD)) u_fram (
        .i_clk(i_clk), .i_we(f_we), .i_addr(f_addr), .i_wdata(i_s_tdata), .o_rdata(f_rdata)
    );
    lrt_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_tram (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr), .i_wdata(i_s_tdata), .o_rdata(t_rdata)
    );

    assign cctl.shift = r_v1;
    assign cctl.gmul  = (r_state == S_GMUL);
    assign cctl.gacc  = (r_state == S_GACC);
    assign cctl.gclr  = (r_state == S_EPOCH);

    assign w_new = sat32(64'(w_arr[r_j]) - 64'(r_stp >>> 16));

    genvar k;
    generate
        for (k = 0; k < NC; k++) begin : g_cell
            if (k + 1 < NC) begin : g_mid
                assign xin[k] = (32'(nf) == k + 1) ? $signed(f_rdata) : x_arr[k + 1];
            end else begin : g_end
                assign xin[k] = $signed(f_rdata);
            end
            always_comb begin
                wwr[k]  = 1'b0;
                wdat[k] = '0;
                if (in_acc && kind == KIND_WEIGHT && 32'(r_wl) == k) begin
                    wwr[k]  = 1'b1;
                    wdat[k] = $signed(i_s_tdata);
                end else if (in_acc && kind == KIND_START && start_ok && r_wl == '0) begin
                    wwr[k]  = 1'b1;
                end else if (r_state == S_UWR && 32'(r_j) == k) begin
                    wwr[k]  = 1'b1;
                    wdat[k] = w_new;
                end
            end
            lrt_cell u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(cctl),
                .i_is_bias(32'(nf) == k), .i_x(xin[k]), .i_err(r_err),
                .i_wwr(wwr[k]), .i_wdata(wdat[k]),
                .o_x(x_arr[k]), .o_w(w_arr[k]), .o_g(g_arr[k])
            );
        end
    endgenerate

    assign div_start = (r_state == S_UDIV);

    lrt_div #(.VW(RW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(g_arr[r_j]), .i_divisor(r_nrows),
        .o_busy(div_busy), .o_done(div_done), .o_quo(div_quo)
    );

    always_ff @(posedge i_clk) begin
        r_j1 <= r_j;
        if (r_v1) begin
            r_prod <= $signed(f_rdata) * w_arr[r_j1];
            if (r_j1 == '0) begin
                r_tgt <= $signed(t_rdata);
            end
        end
        if (r_v2) begin
            r_acc <= sat_add64(r_acc, r_prod);
        end
        if (r_state == S_EPOCH || r_state == S_GACC) begin
            r_acc <= {{16{w_arr[nf][31]}}, w_arr[nf], 16'd0};
        end
        if (r_state == S_PRED) begin
            r_err <= sat32(64'(sat32(r_acc >>> 16)) - 64'(r_tgt));
        end
        if (div_done) begin
            r_q <= div_quo;
        end
        if (r_state == S_UMUL) begin
            r_stp <= sat32(r_q >>> 16) * $signed({1'b0, r_lrate});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_epochs <= 16'd1;
            r_lrate  <= 17'd655;
            r_fiu    <= 5'd1;
            r_rows   <= '0;
            r_col    <= '0;
            r_wl     <= '0;
            r_shape  <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ov     <= 1'b0;
            r_ep     <= '0;
            r_r      <= '0;
            r_j      <= '0;
        end else begin
            r_v1 <= (r_state == S_ISSUE);
            r_v2 <= r_v1;
            if (r_ov && i_m_tready && r_state != S_EMIT && r_state != S_ERRO) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_EPOCHS:   r_epochs <= i_cfg_data[15:0];
                    CFG_LRATE:    r_lrate  <= i_cfg_data;
                    CFG_FEATURES: r_fiu    <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (kind)
                            KIND_FEATURE: begin
                                if (32'(r_col) >= 32'(nf)) begin
                                    r_shape <= 1'b1;
                                end else begin
                                    r_col <= r_col + JW'(1);
                                end
                            end
                            KIND_TARGET: begin
                                if (r_col != nf) begin
                                    r_shape <= 1'b1;
                                end
                                if (32'(r_rows) < MAX_ROWS) begin
                                    r_rows <= r_rows + RW'(1);
                                end
                                r_col <= '0;
                            end
                            KIND_WEIGHT: begin
                                if (32'(r_wl) < MAX_FEATURES + 2) begin
                                    r_wl <= r_wl + WLW'(1);
                                end
                            end
                            default: begin
                                r_nrows  <= r_rows;
                                r_status <= start_st;
                                r_rows   <= '0;
                                r_col    <= '0;
                                r_wl     <= '0;
                                r_shape  <= 1'b0;
                                r_ep     <= '0;
                                r_state  <= start_ok ? S_EPOCH : S_ERRO;
                            end
                        endcase
                    end
                end
                S_EPOCH: begin
                    r_r <= '0;
                    r_j <= '0;
                    r_state <= (r_ep == r_epochs) ? S_EMIT : S_ISSUE;
                end
                S_ISSUE: begin
                    if (r_j == nf - JW'(1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_PRED;
                    end
                end
                S_PRED: r_state <= S_GMUL;
                S_GMUL: r_state <= S_GACC;
                S_GACC: begin
                    r_r <= r_r + RW'(1);
                    r_j <= '0;
                    r_state <= (r_r + RW'(1) == r_nrows) ? S_UDIV : S_ISSUE;
                end
                S_UDIV: r_state <= S_UWAIT;
                S_UWAIT: begin
                    if (div_done) begin
                        r_state <= S_UMUL;
                    end
                end
                S_UMUL: r_state <= S_UWR;
                S_UWR: begin
                    if (r_j == nf) begin
                        r_ep    <= r_ep + 16'd1;
                        r_state <= S_EPOCH;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= S_UDIV;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_od <= {1'b0, STATUS_OK, w_arr[r_j], 5'(r_j)};
                        r_ol <= (r_j == nf);
                        if (r_j == nf) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= r_j + JW'(1);
                        end
                    end
                end
                S_ERRO: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_od    <= {1'b0, r_status, 32'd0, 5'd0};
                        r_ol    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tlast  = r_ol;

    a_div_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_UWAIT))
        else $error("divider busy outside the weight update");
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rows) <= MAX_ROWS)
        else $error("row count beyond capacity");
    a_error_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[38:37] != STATUS_OK) |-> (o_m_tlast && o_m_tdata[4:0] == 5'd0))
        else $error("error result not a single final item");
    a_pipe_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRED) |-> (!r_v1 && !r_v2))
        else $error("prediction taken before accumulation finished");
endmodule

// ===== dv/lrt_checker.sv =====
`timescale 1ns / 1ps
module lrt_checker
    import lrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_weight_results,
    output int          o_error_results
);

    typedef struct {
        logic [4:0]  idx;
        logic [31:0] val;
        logic        last;
        logic [1:0]  status;
    } weight_result_t;

    weight_result_t expected_weights[$];

    int unsigned epochs_reg;
    int unsigned lrate_reg;
    int unsigned features_reg;

    int feat_mem[256*16];
    int tgt_mem[256];
    int w_reg[17];
    int unsigned rows_n;
    int unsigned cols_n;
    int unsigned wcnt;
    bit bad_shape;

    function automatic longint sadd(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        return s;
    endfunction

    function automatic int clamp(input longint x);
        if (x > longint'(32'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (x < -longint'(64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return int'(x);
    endfunction

    function automatic int unsigned live_features();
        if (features_reg == 0) begin
            return 1;
        end else if (features_reg > 16) begin
            return 16;
        end
        return features_reg;
    endfunction

    task automatic train_set(input int unsigned nf);
        longint sums[17];
        longint acc;
        longint err;
        longint g;
        longint step;
        for (int unsigned ep = 0; ep < epochs_reg; ep++) begin
            for (int j = 0; j <= nf; j++) begin
                sums[j] = 0;
            end
            for (int unsigned r = 0; r < rows_n; r++) begin
                acc = longint'(w_reg[nf]) * 65536;
                for (int j = 0; j < nf; j++) begin
                    acc = sadd(acc, longint'(feat_mem[r*16+j]) * longint'(w_reg[j]));
                end
                err = clamp(longint'(clamp(acc >>> 16)) - longint'(tgt_mem[r]));
                for (int j = 0; j < nf; j++) begin
                    sums[j] = sadd(sums[j], err * longint'(feat_mem[r*16+j]));
                end
                sums[nf] = sadd(sums[nf], err * 65536);
            end
            for (int j = 0; j <= nf; j++) begin
                g = clamp((sums[j] / longint'(rows_n)) >>> 16);
                step = (g * longint'(lrate_reg)) >>> 16;
                w_reg[j] = clamp(longint'(w_reg[j]) - step);
            end
        end
    endtask

    task automatic take_request(input logic [1:0] kind, input logic [31:0] value);
        int unsigned nf;
        logic [1:0] st;
        weight_result_t res;
        nf = live_features();
        case (kind)
            KIND_FEATURE: begin
                if (cols_n >= nf) begin
                    bad_shape = 1;
                end else begin
                    if (rows_n < 256) feat_mem[rows_n*16+cols_n] = value;
                    cols_n++;
                end
            end
            KIND_TARGET: begin
                if (cols_n != nf) bad_shape = 1;
                if (rows_n < 256) begin
                    tgt_mem[rows_n] = value;
                    rows_n++;
                end
                cols_n = 0;
            end
            KIND_WEIGHT: begin
                if (wcnt < 17) w_reg[wcnt] = value;
                if (wcnt < 18) wcnt++;
            end
            default: begin
                if (rows_n == 0) begin
                    st = STATUS_EMPTY;
                end else if (bad_shape || cols_n != 0 || (wcnt != 0 && wcnt != nf + 1)) begin
                    st = STATUS_MISMATCH;
                end else begin
                    st = STATUS_OK;
                end
                if (st != STATUS_OK) begin
                    res = '{idx: 5'd0, val: 32'd0, last: 1'b1, status: st};
                    expected_weights.insert(expected_weights.size(), res);
                end else begin
                    if (wcnt == 0) begin
                        for (int j = 0; j < 17; j++) w_reg[j] = 0;
                    end
                    train_set(nf);
                    for (int j = 0; j <= nf; j++) begin
                        res = '{idx: 5'(j), val: w_reg[j], last: (j == nf), status: STATUS_OK};
                        expected_weights.insert(expected_weights.size(), res);
                    end
                end
                rows_n = 0;
                cols_n = 0;
                wcnt = 0;
                bad_shape = 0;
            end
        endcase
    endtask

    task automatic check_result();
        weight_result_t res;
        if (expected_weights.size() == 0) begin
            $display("%0t: unexpected result tdata=%h tlast=%b", $time, i_m_tdata, i_m_tlast);
            o_fail_count++;
            return;
        end
        res = expected_weights.pop_front();
        if (res.status == STATUS_OK) o_weight_results++;
        else o_error_results++;
        if (i_m_tdata[4:0] !== res.idx || i_m_tdata[36:5] !== res.val ||
            i_m_tdata[38:37] !== res.status || i_m_tlast !== res.last) begin
            $display("%0t: mismatch expected idx=%0d val=%h st=%0d last=%b", $time,
                     res.idx, res.val, res.status, res.last);
            $display("%0t:          actual   idx=%0d val=%h st=%0d last=%b", $time,
                     i_m_tdata[4:0], i_m_tdata[36:5], i_m_tdata[38:37], i_m_tlast);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_weight_results = 0;
        o_error_results = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            epochs_reg = 1;
            lrate_reg = 655;
            features_reg = 1;
            for (int j = 0; j < 17; j++) w_reg[j] = 0;
            rows_n = 0;
            cols_n = 0;
            wcnt = 0;
            bad_shape = 0;
            expected_weights.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EPOCHS:   epochs_reg = i_cfg_data[15:0];
                    CFG_LRATE:    lrate_reg = i_cfg_data;
                    CFG_FEATURES: features_reg = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) take_request(i_s_tuser, i_s_tdata);
        end
        o_pending = expected_weights.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import lrt_pkg::*;

    localparam int QUIET_LIMIT = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic [1:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;
    logic        m_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    int fail_count;
    int pending;
    int weight_results;
    int error_results;
    int tx_pct;
    int rx_pct;
    int items_sent;
    int quiet;
    int hold_cnt;
    bit hold_go;
    bit hold_seen;
    int unsigned cur_f;

    linear_regression_trainer_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data), .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data), .o_m_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    lrt_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data), .i_s_tuser(s_user),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data), .i_m_tlast(m_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_weight_results(weight_results), .o_error_results(error_results)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt <= 6000;
            m_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("linear_regression_trainer_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) < 25) return $urandom();
        return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    task automatic send(input logic [1:0] kind, input logic [31:0] value);
        if ($urandom_range(99) < tx_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= kind;
        s_data <= value;
        do @(posedge i_clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
        s_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FEATURES) begin
            cur_f = (value[4:0] == 0) ? 1 : (value[4:0] > 16) ? 16 : value[4:0];
        end
    endtask

    task automatic send_row(input int unsigned n_feat);
        for (int unsigned c = 0; c < n_feat; c++) send(KIND_FEATURE, pick_value());
        send(KIND_TARGET, pick_value());
    endtask

    task automatic load_set(input int unsigned rows, input int n_weights, input int noise);
        for (int w = 0; w < n_weights; w++) send(KIND_WEIGHT, pick_value());
        for (int unsigned r = 0; r < rows; r++) begin
            if (noise == 1 && r == 0) send_row(cur_f + 1);
            else if (noise == 2 && r == rows - 1) send_row(cur_f - 1);
            else send_row(cur_f);
        end
        if (noise == 3) send(KIND_FEATURE, pick_value());
        send(KIND_START, pick_value());
    endtask

    task automatic random_set();
        int unsigned rows;
        int nw;
        int noise;
        int pick;
        if ($urandom_range(99) < 50) begin
            write_reg(CFG_FEATURES, ($urandom_range(99) < 65) ? 17'($urandom_range(1, 3))
                                                              : 17'($urandom_range(0, 31)));
        end
        if ($urandom_range(99) < 50) write_reg(CFG_EPOCHS, 17'($urandom_range(0, 3)));
        if ($urandom_range(99) < 40) begin
            pick = $urandom_range(3);
            write_reg(CFG_LRATE, (pick == 0) ? 17'd0 : (pick == 1) ? 17'd65536 :
                                 17'($urandom_range(0, 65536)));
        end
        rows = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 5);
        pick = $urandom_range(99);
        nw = (pick < 55) ? 0 : (pick < 88) ? cur_f + 1 : $urandom_range(1, cur_f + 3);
        noise = ($urandom_range(99) < 85) ? 0 : $urandom_range(1, 3);
        if (noise == 2 && rows == 0) noise = 0;
        load_set(rows, nw, noise);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = KIND_FEATURE;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_EPOCHS;
        cfg_data = '0;
        hold_go = 1'b0;
        hold_seen = 1'b0;
        hold_cnt = 0;
        quiet = 0;
        items_sent = 0;
        tx_pct = 13;
        rx_pct = 72;
        cur_f = 1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(KIND_FEATURE, 32'h0001_0000);
        send(KIND_TARGET, 32'h0002_0000);
        send(KIND_FEATURE, 32'h7fff_ffff);
        send(KIND_TARGET, 32'h8000_0000);
        send(KIND_START, 32'd0);
        send(KIND_START, 32'hffff_ffff);
        send(KIND_FEATURE, 32'h8000_0000);
        send(KIND_FEATURE, 32'h0000_0001);
        send(KIND_TARGET, 32'h7fff_ffff);
        send(KIND_START, 32'd0);
        send(KIND_TARGET, 32'd5);
        send(KIND_START, 32'd0);
        send(KIND_FEATURE, 32'd7);
        send(KIND_TARGET, 32'd9);
        send(KIND_FEATURE, 32'd7);
        send(KIND_START, 32'd0);
        for (int w = 0; w < 19; w++) send(KIND_WEIGHT, 32'h0003_0000);
        send_row(1);
        send(KIND_START, 32'd0);
        write_reg(CFG_EPOCHS, 17'd0);
        send(KIND_WEIGHT, 32'h8000_0000);
        send(KIND_WEIGHT, 32'h7fff_ffff);
        send_row(1);
        send(KIND_START, 32'd0);
        write_reg(CFG_EPOCHS, 17'd65535);
        send(KIND_START, 32'd0);
        write_reg(CFG_EPOCHS, 17'd2);
        write_reg(CFG_LRATE, 17'd65536);
        write_reg(CFG_FEATURES, 17'd31);
        load_set(2, 17, 0);
        write_reg(CFG_FEATURES, 17'd0);
        write_reg(CFG_EPOCHS, 17'd1);
        write_reg(CFG_LRATE, 17'd0);
        load_set(20, 0, 0);

        for (int i = 0; items_sent < 320; i++) begin
            if (items_sent > 250) begin
                tx_pct = 0;
                rx_pct = 0;
            end else if (items_sent > 190) begin
                tx_pct = 72;
                rx_pct = 13;
            end
            if (i == 0) begin
                load_set(2, 0, 0);
                hold_go <= ~hold_go;
                load_set(3, 0, 0);
            end else begin
                random_set();
            end
        end
        s_valid <= 1'b0;

        do @(negedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        $display("Sent %0d input items over directed and random data sets.", items_sent);
        $display("Checked %0d weight results and %0d error results.",
                 weight_results, error_results);
        if (fail_count == 0 && pending == 0) begin
            $display("linear_regression_trainer_unit regression: pass");
        end else begin
            $display("linear_regression_trainer_unit regression: fail");
        end
        $finish;
    end

endmodule
